/* src/fqpi_pkg.sv */
// Shared types and constants for the queue with positional insert.
// Used by fqpi_cell, fqpi_ctrl and the top level; depends on nothing.
package fqpi_pkg;

	localparam int DEPTH  = 8;
	localparam int WORD_W = 32;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 4;
	localparam int CNT_W  = 4;
	localparam int STAT_W = 2;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int OCC_W  = $clog2(DEPTH + 1);

	localparam int IN_BITS  = CMD_W + WORD_W + POS_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = WORD_W + STAT_W + CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ  = 3'd0,
		CMD_DEQ  = 3'd1,
		CMD_PEEK = 3'd2,
		CMD_CLR  = 3'd3,
		CMD_INS  = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP
	} cell_op_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos;
		logic [WORD_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		status_t           status;
		logic [WORD_W-1:0] data;
	} result_t;

endpackage

/* src/fqpi_cell.sv */
// One storage cell of the queue chain: holds one word, takes its left or right
// neighbour or the new word as the broadcast control says. Depends on fqpi_pkg.
module fqpi_cell (
	input  logic                              clk,
	input  logic [fqpi_pkg::IDX_W-1:0]        idx,
	input  fqpi_pkg::cell_ctl_t               ctl,
	input  logic signed [fqpi_pkg::WORD_W-1:0] left,
	input  logic signed [fqpi_pkg::WORD_W-1:0] right,
	output logic signed [fqpi_pkg::WORD_W-1:0] word_q
);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			fqpi_pkg::CELL_PUSH: begin
				if (idx == ctl.pos) begin
					word_q <= ctl.value;
				end else if (idx > ctl.pos) begin
					word_q <= left;
				end
			end
			fqpi_pkg::CELL_POP: begin
				word_q <= right;
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/fqpi_ctrl.sv */
// Command decode and occupancy tracking for the queue; drives the cell chain
// and forms the result of each command. Depends on fqpi_pkg.
module fqpi_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              acc,
	input  logic [fqpi_pkg::CMD_W-1:0]        cmd,
	input  logic signed [fqpi_pkg::WORD_W-1:0] value,
	input  logic [fqpi_pkg::POS_W-1:0]        position,
	input  logic signed [fqpi_pkg::WORD_W-1:0] head,
	output fqpi_pkg::cell_ctl_t               ctl,
	output fqpi_pkg::result_t                 res
);

	logic [fqpi_pkg::OCC_W-1:0] occ_q;
	logic [fqpi_pkg::OCC_W-1:0] occ_d;
	logic                       empty;
	logic                       full;

	assign empty = (occ_q == '0);
	assign full  = (occ_q == fqpi_pkg::OCC_W'(fqpi_pkg::DEPTH));

	always_comb begin
		ctl.op     = fqpi_pkg::CELL_HOLD;
		ctl.pos    = fqpi_pkg::IDX_W'(occ_q);
		ctl.value  = value;
		occ_d      = occ_q;
		res.status = fqpi_pkg::ST_OK;
		res.data   = empty ? '1 : head;
		unique case (cmd)
			fqpi_pkg::CMD_ENQ: begin
				if (full) begin
					res.status = fqpi_pkg::ST_FULL;
				end else begin
					ctl.op = fqpi_pkg::CELL_PUSH;
					occ_d  = occ_q + 1'b1;
					if (empty) begin
						res.data = value;
					end
				end
			end
			fqpi_pkg::CMD_DEQ: begin
				if (empty) begin
					res.status = fqpi_pkg::ST_EMPTY;
				end else begin
					ctl.op = fqpi_pkg::CELL_POP;
					occ_d  = occ_q - 1'b1;
				end
			end
			fqpi_pkg::CMD_PEEK: begin
				if (empty) begin
					res.status = fqpi_pkg::ST_EMPTY;
				end
			end
			fqpi_pkg::CMD_CLR: begin
				occ_d    = '0;
				res.data = '1;
			end
			fqpi_pkg::CMD_INS: begin
				if (full) begin
					res.status = fqpi_pkg::ST_FULL;
				end else if (32'(position) > 32'(occ_q)) begin
					res.status = fqpi_pkg::ST_BADPOS;
				end else begin
					ctl.op  = fqpi_pkg::CELL_PUSH;
					ctl.pos = fqpi_pkg::IDX_W'(position);
					occ_d   = occ_q + 1'b1;
					// Inserting at the head makes the new word the head.
					if (position == '0) begin
						res.data = value;
					end
				end
			end
			default: begin
			end
		endcase
		if (!acc) begin
			ctl.op = fqpi_pkg::CELL_HOLD;
		end
		res.count = fqpi_pkg::CNT_W'(occ_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (acc) begin
			occ_q <= occ_d;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= fqpi_pkg::OCC_W'(fqpi_pkg::DEPTH))
		else $error("occupancy beyond depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == fqpi_pkg::CMD_CLR |=> occ_q == '0)
		else $error("clear left words in the queue");

	a_peek_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == fqpi_pkg::CMD_PEEK |=> occ_q == $past(occ_q))
		else $error("peek changed the occupancy");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |-> ctl.op == fqpi_pkg::CELL_HOLD)
		else $error("cells moved without an accepted beat");

endmodule

/* src/fifo_queue_with_positional_insert.sv */
// Top level of the bounded queue with positional insert: a chain of word cells,
// the command controller and an output result register. Depends on fqpi_pkg,
// fqpi_cell and fqpi_ctrl.
//
//  Channel | Direction | Beat contents
//  s_*     | in        | tdata: cmd[2:0], value[34:3], position[38:35], zero pad
//  m_*     | out       | tdata: data[31:0], status[33:32], count[37:34], zero pad
//
// Every command completes at the edge that accepts it: all cells shift, take the new
// word or hold in parallel, so a beat can be accepted on every clock edge unless a waiting result is stalled.
// The result register is the only stage; a new command is taken while the
// previous result is being taken in the same cycle.
// Reset clears the occupancy and empties the result register; the stored words
// are left as they are and are never read before being written.
// While m_tready is low with a result waiting, s_tready stays low.
module fifo_queue_with_positional_insert (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fqpi_pkg::IN_W-1:0]       s_tdata,  // cmd, value, position
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fqpi_pkg::OUT_W-1:0]      m_tdata   // data, status, count
);

	logic                               acc;
	logic [fqpi_pkg::CMD_W-1:0]         cmd;
	logic signed [fqpi_pkg::WORD_W-1:0] value;
	logic [fqpi_pkg::POS_W-1:0]         position;
	logic signed [fqpi_pkg::WORD_W-1:0] word_q [fqpi_pkg::DEPTH];
	fqpi_pkg::cell_ctl_t                ctl;
	fqpi_pkg::result_t                  res;
	fqpi_pkg::result_t                  res_q;
	logic                               out_valid_q;

	assign cmd      = s_tdata[fqpi_pkg::CMD_W-1:0];
	assign value    = s_tdata[fqpi_pkg::CMD_W +: fqpi_pkg::WORD_W];
	assign position = s_tdata[fqpi_pkg::CMD_W + fqpi_pkg::WORD_W +: fqpi_pkg::POS_W];

	assign s_tready = !out_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	fqpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.cmd      (cmd),
		.value    (value),
		.position (position),
		.head     (word_q[0]),
		.ctl      (ctl),
		.res      (res)
	);

	for (genvar i = 0; i < fqpi_pkg::DEPTH; i++) begin : g_cell
		logic signed [fqpi_pkg::WORD_W-1:0] left;
		logic signed [fqpi_pkg::WORD_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = word_q[i];
		end else begin : g_mid_l
			assign left = word_q[i-1];
		end
		if (i == fqpi_pkg::DEPTH - 1) begin : g_last
			assign right = word_q[i];
		end else begin : g_mid_r
			assign right = word_q[i+1];
		end

		fqpi_cell u_cell (
			.clk    (clk),
			.idx    (fqpi_pkg::IDX_W'(i)),
			.ctl    (ctl),
			.left   (left),
			.right  (right),
			.word_q (word_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = fqpi_pkg::OUT_W'(res_q);

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.status == fqpi_pkg::ST_FULL
		|-> res_q.count == fqpi_pkg::CNT_W'(fqpi_pkg::DEPTH))
		else $error("full refusal with room left");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.status == fqpi_pkg::ST_EMPTY
		|-> res_q.count == '0 && res_q.data == '1)
		else $error("empty refusal with words held or wrong data");

endmodule

/* tb/sv/fifo_queue_with_positional_insert_tb.sv */
// Self-checking testbench for the bounded queue with positional insert.
// Drives commands into the s_* stream and compares m_* beats against its own queue model.
// Depends on fqpi_pkg and fifo_queue_with_positional_insert.
module fifo_queue_with_positional_insert_tb;
	import fqpi_pkg::*;

	localparam logic [CMD_W-1:0]  CMD_SPARE_FIRST = CMD_W'(CMD_INS + 1);
	localparam logic [CMD_W-1:0]  CMD_SPARE_LAST  = '1;
	localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] WORD_NEG = 32'hffff_ffff;
	localparam int                ITEMS_PER_PHASE = 170;

	// Mirrors the queue contents and keeps the replies still owed by the block.
	class queue_scoreboard;
		logic [WORD_W-1:0] words [DEPTH];
		int                held;
		result_t           replies_due[$];
		int                errors;

		function new();
			held   = 0;
			errors = 0;
		endfunction

		function void note_command(input logic [IN_W-1:0] beat);
			logic [CMD_W-1:0]  op;
			logic [WORD_W-1:0] word;
			logic [WORD_W-1:0] removed;
			int                pos;
			int                i;
			logic              popped;
			result_t           r;
			op       = beat[CMD_W-1:0];
			word     = beat[CMD_W +: WORD_W];
			pos      = int'(beat[CMD_W+WORD_W +: POS_W]);
			popped   = 1'b0;
			removed  = '0;
			r.status = ST_OK;
			case (op)
				CMD_ENQ: begin
					if (held >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						words[held] = word;
						held++;
					end
				end
				CMD_DEQ: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						removed = words[0];
						popped  = 1'b1;
						for (i = 1; i < held; i++)
							words[i-1] = words[i];
						held--;
					end
				end
				CMD_PEEK: begin
					if (held == 0)
						r.status = ST_EMPTY;
				end
				CMD_CLR: begin
					held = 0;
				end
				CMD_INS: begin
					// Fullness takes precedence over a bad position.
					if (held >= DEPTH) begin
						r.status = ST_FULL;
					end else if (pos > held) begin
						r.status = ST_BADPOS;
					end else begin
						for (i = held; i > pos; i--)
							words[i] = words[i-1];
						words[pos] = word;
						held++;
					end
				end
				default: begin
				end
			endcase
			if (popped)
				r.data = removed;
			else
				r.data = (held == 0) ? WORD_NEG : words[0];
			r.count = held[CNT_W-1:0];
			replies_due.push_back(r);
		endfunction

		function void check_result(input logic [OUT_W-1:0] beat);
			result_t got;
			result_t want;
			got = result_t'(beat[OUT_BITS-1:0]);
			if (replies_due.size() == 0) begin
				$error("result beat with no command outstanding: %h", beat);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			if (got.data !== want.data) begin
				$error("data: expected %h, actual %h", want.data, got.data);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("count: expected %0d, actual %0d", want.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	int                send_idle_pct = 0;
	int                stall_pct = 0;
	queue_scoreboard   sb;

	fifo_queue_with_positional_insert dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Results are checked before the command of the same edge is noted, so a reply can
	// never be matched with a command that was taken in the very same cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_command(s_tdata);
		end
	end

	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] word,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({pos, word, op});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(input int n);
		int                fill_bias;
		int                pick;
		logic [CMD_W-1:0]  op;
		logic [WORD_W-1:0] word;
		logic [POS_W-1:0]  pos;
		fill_bias = 50;
		for (int k = 0; k < n; k++) begin
			// Swing between filling and draining so that both full and empty are visited often.
			if (k % 24 == 0)
				fill_bias = $urandom_range(15, 85);
			pick = $urandom_range(99);
			if (pick < 3)
				op = CMD_CLR;
			else if (pick < 6)
				op = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
			else if (pick < 14)
				op = CMD_PEEK;
			else if ($urandom_range(99) < fill_bias)
				op = $urandom_range(1) ? CMD_ENQ : CMD_INS;
			else
				op = CMD_DEQ;
			pick = $urandom_range(99);
			if (pick < 15)
				pos = '0;
			else if (pick < 85)
				pos = POS_W'($urandom_range(DEPTH));
			else
				pos = POS_W'($urandom_range(DEPTH + 1, 2**POS_W - 1));
			case ($urandom_range(39))
				0:       word = WORD_MIN;
				1:       word = WORD_MAX;
				2:       word = '0;
				3:       word = WORD_NEG;
				default: word = $urandom;
			endcase
			send_cmd(op, word, pos);
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty and full refusals, extremes, head, middle and tail inserts.
		send_cmd(CMD_PEEK, '0, '0);
		send_cmd(CMD_DEQ, '0, '0);
		send_cmd(CMD_INS, 32'h1234_5678, 4'd1);
		send_cmd(CMD_INS, WORD_MAX, 4'd0);
		send_cmd(CMD_ENQ, WORD_MIN, '0);
		send_cmd(CMD_ENQ, '0, '0);
		send_cmd(CMD_ENQ, WORD_NEG, '0);
		send_cmd(CMD_INS, 32'h5a5a_5a5a, 4'd4);
		send_cmd(CMD_INS, 32'ha5a5_a5a5, 4'd2);
		send_cmd(CMD_ENQ, 32'h0000_0001, '0);
		send_cmd(CMD_ENQ, 32'hfffffffe, '0);
		send_cmd(CMD_ENQ, 32'h0f0f_0f0f, '0);
		send_cmd(CMD_ENQ, 32'hdead_beef, '0);
		send_cmd(CMD_INS, 32'hcafe_f00d, 4'd0);
		send_cmd(CMD_DEQ, '0, '0);
		send_cmd(CMD_INS, 32'h1111_1111, 4'd9);
		send_cmd(CMD_INS, 32'h2222_2222, 4'd15);
		send_cmd(CMD_INS, 32'h3333_3333, 4'd0);
		send_cmd(CMD_SPARE_FIRST, WORD_NEG, 4'd15);
		send_cmd(CMD_SPARE_LAST, '0, '0);
		send_cmd(CMD_PEEK, '0, '0);
		send_cmd(CMD_DEQ, '0, '0);
		send_cmd(CMD_CLR, WORD_NEG, 4'd15);
		send_cmd(CMD_PEEK, '0, '0);
		send_cmd(CMD_W'(CMD_SPARE_FIRST + 1), '0, '0);

		send_random(ITEMS_PER_PHASE);

		send_idle_pct = 56;
		stall_pct     = 0;
		send_random(ITEMS_PER_PHASE);

		// Let the block drain completely before carrying on.
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(negedge clk);

		send_idle_pct = 0;
		stall_pct     = 56;
		send_random(ITEMS_PER_PHASE);

		send_idle_pct = 33;
		stall_pct     = 33;
		send_random(ITEMS_PER_PHASE);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
